// ----- rtl/positional_list_engine_unit_assert.svh -----
// Assertion macros for the positional list engine checker.
// Users must have clk_i and rst_ni in scope.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

// ----- rtl/ple_pkg.sv -----
// Shared types and codes of the positional list engine.
// No dependencies.
`default_nettype none

package ple_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RPOS_W   = 4;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    PLAN_DONE,
    PLAN_INS,
    PLAN_REM,
    PLAN_FIND,
    PLAN_READ
  } ple_plan_e;

  typedef enum logic [1:0] {
    ADDR_PREV,
    ADDR_NEXT,
    ADDR_HERE
  } ple_addr_e;

  typedef struct packed {
    logic      accept;
    logic      rd_en;
    ple_addr_e rd_sel;
    logic      write_shift;
    logic      ptr_down;
    logic      ptr_up;
    logic      put;
    logic      drop;
    logic      miss;
    logic      hit;
    logic      fetch;
    logic      publish;
  } ple_cmd_t;

  typedef struct packed {
    ple_plan_e plan;
    logic      up_done;
    logic      dn_done;
    logic      sc_done;
    logic      match;
    logic      out_full;
  } ple_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ple_if.sv -----
// Channel interfaces of the positional list engine: request, result, config.
// Depends on ple_pkg.
`default_nettype none

interface ple_req_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [POS_W-1:0]  position;
  logic [VALUE_W-1:0]       value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
  modport mon    (input valid, ready, mode, position, value);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RPOS_W-1:0]   result_position;
  logic [VALUE_W-1:0]  read_value;
  logic [TOTAL_W-1:0]  entry_total;
  logic                is_empty;

  modport source (output valid, status, result_position, read_value, entry_total, is_empty,
                  input ready);
  modport sink   (input valid, status, result_position, read_value, entry_total, is_empty,
                  output ready);
  modport mon    (input valid, ready, status, result_position, read_value, entry_total,
                  is_empty);
endinterface

interface ple_cfg_if import ple_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

`default_nettype wire

// ----- rtl/ple_ctrl.sv -----
// Sequencer of the positional list engine: steps shifts, scans and reads.
// Depends on ple_pkg.
`default_nettype none

module ple_ctrl import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  ple_stat_t stat_i,
  output ple_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_TEST = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_WR   = 4'd3;
  localparam logic [3:0] S_PUT     = 4'd4;
  localparam logic [3:0] S_DN_TEST = 4'd5;
  localparam logic [3:0] S_DN_RD   = 4'd6;
  localparam logic [3:0] S_DN_WR   = 4'd7;
  localparam logic [3:0] S_DN_END  = 4'd8;
  localparam logic [3:0] S_SC_TEST = 4'd9;
  localparam logic [3:0] S_SC_RD   = 4'd10;
  localparam logic [3:0] S_SC_CMP  = 4'd11;
  localparam logic [3:0] S_RD_RD   = 4'd12;
  localparam logic [3:0] S_RD_GET  = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  logic [3:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (stat_i.plan)
            PLAN_INS:  state_d = S_UP_TEST;
            PLAN_REM:  state_d = S_DN_TEST;
            PLAN_FIND: state_d = S_SC_TEST;
            PLAN_READ: state_d = S_RD_RD;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_UP_TEST: state_d = stat_i.up_done ? S_PUT : S_UP_RD;
      S_UP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_PREV;
        state_d      = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.write_shift = 1'b1;
        cmd_o.ptr_down    = 1'b1;
        state_d           = S_UP_TEST;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_FIN;
      end
      S_DN_TEST: state_d = stat_i.dn_done ? S_DN_END : S_DN_RD;
      S_DN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_NEXT;
        state_d      = S_DN_WR;
      end
      S_DN_WR: begin
        cmd_o.write_shift = 1'b1;
        cmd_o.ptr_up      = 1'b1;
        state_d           = S_DN_TEST;
      end
      S_DN_END: begin
        cmd_o.drop = 1'b1;
        state_d    = S_FIN;
      end
      S_SC_TEST: begin
        if (stat_i.sc_done) begin
          cmd_o.miss = 1'b1;
          state_d    = S_FIN;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_HERE;
        state_d      = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (stat_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_FIN;
        end else begin
          cmd_o.ptr_up = 1'b1;
          state_d      = S_SC_TEST;
        end
      end
      S_RD_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_HERE;
        state_d      = S_RD_GET;
      end
      S_RD_GET: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_full) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ple_dp.sv -----
// Datapath of the positional list engine: entry memory, count, capacity,
// position resolution and the result register. Depends on ple_pkg.
`default_nettype none

module ple_dp import ple_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ple_cmd_t                cmd_i,
  output ple_stat_t               stat_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic signed [POS_W-1:0] position_i,
  input  logic [VALUE_W-1:0]      value_i,
  input  logic                    rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [RPOS_W-1:0]       result_position_o,
  output logic [VALUE_W-1:0]      read_value_o,
  output logic [TOTAL_W-1:0]      entry_total_o,
  output logic                    is_empty_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        capacity_limit_i
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned EW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic [CNT_W-1:0]      rpos_q, rpos_d;
  logic [DATA_WIDTH-1:0] rval_q, rval_d;

  logic [DATA_WIDTH-1:0] mem_q [LIST_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [RPOS_W-1:0]     out_rpos_q;
  logic [VALUE_W-1:0]    out_rval_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic                  out_empty_q;

  logic signed [EW-1:0]  pos_x, cnt_x, sum_x;
  logic                  pos_ok, empty, ins_empty_ok, full;
  logic [CNT_W-1:0]      res_idx, ins_idx;
  logic [EW-1:0]         cap_x, cap_eff;
  logic [63:0]           val_w, rval_w;
  logic [15:0]           rpos_w, total_w;
  logic [DATA_WIDTH-1:0] val_in;
  ple_plan_e             plan;
  logic [STATUS_W-1:0]   imm_st;
  logic [CNT_W-1:0]      rd_ptr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [CNT_W:0]        ptr_next_x;

  // position resolution, negative counts back from the end
  assign pos_x   = {{(EW-POS_W){position_i[POS_W-1]}}, position_i};
  assign cnt_x   = signed'(EW'(count_q));
  assign sum_x   = cnt_x + pos_x;
  assign pos_ok  = position_i[POS_W-1] ? !sum_x[EW-1] : (pos_x < cnt_x);
  assign res_idx = position_i[POS_W-1] ? sum_x[CNT_W-1:0] : pos_x[CNT_W-1:0];

  assign empty        = (count_q == '0);
  assign ins_empty_ok = (position_i == '0) || (position_i == '1);
  assign ins_idx      = empty ? '0 : res_idx + CNT_W'(mode_i == MODE_INS_AFTER);

  assign cap_x = EW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = EW'(1);
    end else if (cap_x > EW'(LIST_DEPTH)) begin
      cap_eff = EW'(LIST_DEPTH);
    end else begin
      cap_eff = cap_x;
    end
  end
  assign full = (EW'(count_q) >= cap_eff);

  assign val_w  = 64'(value_i);
  assign val_in = val_w[DATA_WIDTH-1:0];

  always_comb begin
    plan   = PLAN_DONE;
    imm_st = ST_OK;
    unique case (mode_i)
      MODE_INS_BEFORE, MODE_INS_AFTER: begin
        if (full) begin
          imm_st = ST_FULL;
        end else if (empty ? !ins_empty_ok : !pos_ok) begin
          imm_st = ST_BAD_POS;
        end else begin
          plan = PLAN_INS;
        end
      end
      MODE_REMOVE: begin
        if (!pos_ok) imm_st = ST_BAD_POS;
        else plan = PLAN_REM;
      end
      MODE_FIND: begin
        if (!pos_ok) imm_st = ST_BAD_POS;
        else plan = PLAN_FIND;
      end
      MODE_READ: begin
        if (!pos_ok) imm_st = ST_BAD_POS;
        else plan = PLAN_READ;
      end
      MODE_CLEAR: imm_st = ST_OK;
      default:    imm_st = ST_BAD_POS;
    endcase
  end

  always_comb begin
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    val_d    = val_q;
    res_st_d = res_st_q;
    rpos_d   = rpos_q;
    rval_d   = rval_q;
    count_d  = count_q;
    if (cmd_i.accept) begin
      ptr_d    = (plan == PLAN_INS) ? count_q : res_idx;
      idx_d    = ins_idx;
      val_d    = val_in;
      res_st_d = imm_st;
      rval_d   = '0;
      if (plan == PLAN_DONE) rpos_d = '0;
      else if (plan == PLAN_INS) rpos_d = ins_idx;
      else rpos_d = res_idx;
      if (mode_i == MODE_CLEAR) count_d = '0;
    end
    if (cmd_i.ptr_down) ptr_d = ptr_q - CNT_W'(1);
    if (cmd_i.ptr_up) ptr_d = ptr_q + CNT_W'(1);
    if (cmd_i.put) count_d = count_q + CNT_W'(1);
    if (cmd_i.drop) count_d = count_q - CNT_W'(1);
    if (cmd_i.miss) begin
      res_st_d = ST_NOT_FOUND;
      rpos_d   = '0;
    end
    if (cmd_i.hit) begin
      res_st_d = ST_OK;
      rpos_d   = ptr_q;
    end
    if (cmd_i.fetch) rval_d = rdata_q;
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      ADDR_PREV: rd_ptr = ptr_q - CNT_W'(1);
      ADDR_NEXT: rd_ptr = ptr_q + CNT_W'(1);
      ADDR_HERE: rd_ptr = ptr_q;
      default:   rd_ptr = ptr_q;
    endcase
  end

  assign wr_en   = cmd_i.write_shift | cmd_i.put;
  assign wr_addr = cmd_i.put ? idx_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
  assign wr_data = cmd_i.put ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem_q[rd_ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    val_q    <= val_d;
    res_st_q <= res_st_d;
    rpos_q   <= rpos_d;
    rval_q   <= rval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) cap_q <= capacity_limit_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  assign ptr_next_x     = {1'b0, ptr_q} + (CNT_W+1)'(1);
  assign stat_o.plan    = plan;
  assign stat_o.up_done = (ptr_q == idx_q);
  assign stat_o.dn_done = (ptr_next_x >= {1'b0, count_q});
  assign stat_o.sc_done = (ptr_q >= count_q);
  assign stat_o.match   = (rdata_q == val_q);
  assign stat_o.out_full = out_valid_q & ~rsp_ready_i;

  // result register
  assign rval_w  = 64'(rval_q);
  assign rpos_w  = 16'(rpos_q);
  assign total_w = 16'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_q <= res_st_q;
      out_rpos_q   <= rpos_w[RPOS_W-1:0];
      out_rval_q   <= rval_w[VALUE_W-1:0];
      out_total_q  <= total_w[TOTAL_W-1:0];
      out_empty_q  <= empty;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign result_position_o = out_rpos_q;
  assign read_value_o      = out_rval_q;
  assign entry_total_o     = out_total_q;
  assign is_empty_o        = out_empty_q;

endmodule

`default_nettype wire

// ----- rtl/positional_list_engine_unit.sv -----
// Positional list engine top level: sequencer plus datapath.
// Depends on ple_pkg, ple_if, ple_ctrl and ple_dp.
`default_nettype none

// Ordered list of up to LIST_DEPTH words with insert before/after, remove,
// find, read and clear at signed positions (negative counts from the end).
// One request is worked at a time; the next is taken once the previous one
// has reached the result register. Entries live in a single-port-read
// memory, so shifts and scans move one entry at a time, each through a
// test, a read and a write or compare state. A clear or a rejected request
// goes straight to the result step; a read reads entry k and fetches it; an
// insert that writes entry j first moves entries j and above up by one; a
// remove shifts the entries above k down and then lowers the count; a find
// examines entries from k on until one matches or the list ends. The last
// step waits while the result register holds a result not yet taken.
// A result that is not taken stalls the request side after the next one.
module positional_list_engine_unit import ple_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp,
  ple_cfg_if.sink   cfg
);

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ple_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (req.mode),
    .position_i        (req.position),
    .value_i           (req.value),
    .rsp_ready_i       (rsp.ready),
    .rsp_valid_o       (rsp.valid),
    .status_o          (rsp.status),
    .result_position_o (rsp.result_position),
    .read_value_o      (rsp.read_value),
    .entry_total_o     (rsp.entry_total),
    .is_empty_o        (rsp.is_empty),
    .cfg_valid_i       (cfg.valid),
    .cfg_ready_o       (cfg.ready),
    .capacity_limit_i  (cfg.capacity_limit)
  );

endmodule

`default_nettype wire

// ----- rtl/ple_chk.sv -----
// Port-level checks of the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_unit_assert.svh.
`default_nettype none
`include "positional_list_engine_unit_assert.svh"

module ple_chk import ple_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_st_i,
  input logic [RPOS_W-1:0]   rsp_pos_i,
  input logic [VALUE_W-1:0]  rsp_val_i,
  input logic [TOTAL_W-1:0]  rsp_total_i,
  input logic                rsp_empty_i
);

  `PLE_ASSERT_IMPL(a_empty_total, rsp_valid_i, rsp_empty_i == (rsp_total_i == '0))
  `PLE_ASSERT_IMPL(a_fail_pos_zero, rsp_valid_i && (rsp_st_i != ST_OK), rsp_pos_i == '0)
  `PLE_ASSERT_NEXT(a_one_in_flight, req_valid_i && req_ready_i, !req_ready_i)
  `PLE_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_val_i))
  `PLE_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_st_i) && $stable(rsp_pos_i))

endmodule

bind positional_list_engine_unit ple_chk u_ple_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_st_i    (rsp.status),
  .rsp_pos_i   (rsp.result_position),
  .rsp_val_i   (rsp.read_value),
  .rsp_total_i (rsp.entry_total),
  .rsp_empty_i (rsp.is_empty)
);

`default_nettype wire
